@@ src/bns_pkg.sv @@
// ----------------------------------------------------------------------------
// bns_pkg: shared types and constants for the barrier Newton step block
// Beat layouts, operation and fault codes, sequencer states and the
// fixed-point helpers used by the datapath.
// ----------------------------------------------------------------------------
package bns_pkg;

    localparam int MAX_ROWS  = 8;
    localparam int ROW_AW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ROW_CW    = $clog2(MAX_ROWS + 1);
    localparam int FRAC_BITS = 24;

    localparam logic signed [31:0] WMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] WMIN = 32'sh8000_0000;

    localparam logic signed [31:0] DIR_RESET  = 32'sd1677722;
    localparam logic [3:0]         ROWS_RESET = 4'd4;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STEP  = 2'd2;

    localparam logic [1:0] FAULT_OK    = 2'd0;
    localparam logic [1:0] FAULT_SLACK = 2'd1;
    localparam logic [1:0] FAULT_SING  = 2'd2;

    localparam logic [1:0] CFG_DIR_C0 = 2'd0;
    localparam logic [1:0] CFG_DIR_C1 = 2'd1;
    localparam logic [1:0] CFG_ROWS   = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic [2:0]         row_index;
        logic signed [31:0] row_a0;
        logic signed [31:0] row_a1;
        logic signed [31:0] row_b;
        logic signed [31:0] start_x0;
        logic signed [31:0] start_x1;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] point_x0;
        logic signed [31:0] point_x1;
        logic [15:0]        point_number;
        logic [1:0]         fault;
    } res_t;

    typedef struct packed {
        logic signed [31:0] a0;
        logic signed [31:0] a1;
        logic signed [31:0] b;
    } row_t;

    typedef enum logic [4:0] {
        S_IDLE, S_RD, S_M0, S_M1, S_SLACK,
        S_U0, S_U0W, S_U1, S_U1W,
        S_Q0, S_Q1, S_Q2, S_Q3,
        S_DET0, S_DET1, S_N0A, S_N0B, S_N0C, S_N1B, S_N1C,
        S_D0, S_D0W, S_D1, S_D1W, S_UPD, S_DONE
    } state_t;

    // Q16.48 product of two Q8.24 words back to Q16.24, rounding toward zero
    function automatic logic signed [39:0] trunc_q(input logic signed [63:0] p);
        logic signed [63:0] t;
        begin
            t = (p < 0) ? (p + 64'sd16777215) : p;
            return t[63:24];
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        begin
            if (v > 64'(WMAX))
                return WMAX;
            else if (v < 64'(WMIN))
                return WMIN;
            else
                return v[31:0];
        end
    endfunction

    function automatic logic signed [63:0] sat64(input logic signed [64:0] v);
        begin
            if (v[64] != v[63])
                return v[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            else
                return v[63:0];
        end
    endfunction

endpackage

@@ src/bns_row_ram.sv @@
// ----------------------------------------------------------------------------
// bns_row_ram: constraint row store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bns_row_ram (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [bns_pkg::ROW_AW-1:0] wr_addr,
    input  bns_pkg::row_t              wr_data,
    input  logic                       rd_en,
    input  logic [bns_pkg::ROW_AW-1:0] rd_addr,
    output bns_pkg::row_t              rd_data
);

    bns_pkg::row_t mem [bns_pkg::MAX_ROWS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ src/bns_div.sv @@
// ----------------------------------------------------------------------------
// bns_div: Q8.24 quotient unit
// num * 2^24 / den, truncated toward zero, saturated to a word;
// restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bns_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] num,
    input  logic signed [63:0] den,
    output logic               done,
    output logic signed [31:0] quo
);

    logic        run_reg, fin_reg, done_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] rem_reg, ud_reg;
    logic [31:0] sh_reg, q_reg;
    logic        neg_reg, ovf_reg, zero_reg;
    logic signed [31:0] quo_reg;

    logic [63:0] un, ud;
    logic [64:0] r2;
    logic        ge;
    logic [32:0] m;
    logic signed [31:0] fin_val;

    always_comb
    begin
        un = num[63] ? (64'd0 - num) : num;
        ud = den[63] ? (64'd0 - den) : den;
        r2 = {rem_reg, sh_reg[31]};
        ge = (r2 >= {1'b0, ud_reg});
        m  = ovf_reg ? {1'b1, 32'd0} : {1'b0, q_reg};
        if (zero_reg)
            fin_val = '0;
        else if (!neg_reg)
            fin_val = (m > 33'h0_7FFF_FFFF) ? bns_pkg::WMAX : m[31:0];
        else if (m > 33'h0_8000_0000)
            fin_val = bns_pkg::WMIN;
        else
            fin_val = 32'(33'd0 - m);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= !start && run_reg && (cnt_reg == 6'd1);
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 6'd32;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg  <= num[63] ^ den[63];
            zero_reg <= (ud == 64'd0);
            ovf_reg  <= ({8'd0, un} >= {ud, 8'd0});
            ud_reg   <= ud;
            rem_reg  <= {8'd0, un[63:8]};
            sh_reg   <= {un[7:0], 24'd0};
            q_reg    <= '0;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? 64'(r2 - {1'b0, ud_reg}) : r2[63:0];
            sh_reg  <= {sh_reg[30:0], 1'b0};
            q_reg   <= {q_reg[30:0], ge};
        end
        if (fin_reg)
        begin
            quo_reg <= fin_val;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

@@ src/barrier_newton_step_2d.sv @@
// ----------------------------------------------------------------------------
// barrier_newton_step_2d: affine-scaling step for a 2-D point
// Row table in a synchronous RAM, one shared 32x32 multiplier and an
// iterative quotient unit, run by a step sequencer.
//
//  channel   | signals                              | handshake
//  ----------+--------------------------------------+-------------------------
//  command   | start, busy, cmd                     | beat when start & !busy
//  result    | done, result                         | one-cycle strobe
//  config    | cfg_wr_en, cfg_index, cfg_data       | write when cfg_wr_en
//
// A start emits its point on the next cycle. A step holds busy until its
// point is ready and emits it in the cycle after busy falls: each row does a
// RAM read, two multiplies, the slack check and two divides and then three
// multiplies, and the end does the determinant and numerator multiplies,
// two more divides, the update and the emit. Zero slack or a singular H cuts
// the step short. Reset clears the point, the counter, the strobe and the
// fault code and restores the configuration; rows stay unknown until loaded.
// The receiver cannot stall: each result shows for one cycle.
// ----------------------------------------------------------------------------
module barrier_newton_step_2d (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  bns_pkg::cmd_t      cmd,
    output logic               done,
    output bns_pkg::res_t      result,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    bns_pkg::state_t state_reg, state_next;

    // configuration
    logic signed [31:0] c0_reg, c1_reg;
    logic [3:0]         rows_reg;

    // architectural state
    logic signed [31:0] x0_reg, x1_reg;
    logic [15:0]        cnt_reg;

    // step datapath
    logic [bns_pkg::ROW_CW-1:0] nrows_reg, idx_reg;
    logic signed [39:0] t0_reg;
    logic signed [63:0] s_reg;
    logic signed [31:0] u0_reg, u1_reg, d0_reg;
    logic signed [63:0] h00_reg, h01_reg, h11_reg;
    logic signed [63:0] pa_reg, det_reg, n0_reg, n1_reg;
    logic signed [63:0] prod_reg;
    logic [1:0]         fault_reg;

    // result beat
    bns_pkg::res_t res_reg;
    logic          done_reg;

    logic accept;
    bns_pkg::row_t rd_row;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    logic signed [41:0] slack;
    logic signed [39:0] tprod;
    logic signed [31:0] hw00, hw01, hw11;
    logic [bns_pkg::ROW_CW-1:0] nrows_clamp;

    logic               div_start, div_done;
    logic signed [63:0] div_num, div_den;
    logic signed [31:0] div_quo;

    assign accept = start && (state_reg == bns_pkg::S_IDLE);
    assign busy   = (state_reg != bns_pkg::S_IDLE);

    // single 32x32 signed multiplier with a full 64-bit product
    assign mul_p = mul_a * mul_b;

    bns_row_ram u_ram (
        .clk     (clk),
        .wr_en   (accept && cmd.operation == bns_pkg::OP_LOAD &&
                  {1'b0, cmd.row_index} < 4'(bns_pkg::MAX_ROWS)),
        .wr_addr (bns_pkg::ROW_AW'(cmd.row_index)),
        .wr_data ({cmd.row_a0, cmd.row_a1, cmd.row_b}),
        .rd_en   (state_reg == bns_pkg::S_RD),
        .rd_addr (idx_reg[bns_pkg::ROW_AW-1:0]),
        .rd_data (rd_row)
    );

    bns_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        tprod = bns_pkg::trunc_q(prod_reg);
        slack = 42'(t0_reg) + 42'(tprod) - 42'(rd_row.b);
        hw00  = bns_pkg::sat32(h00_reg);
        hw01  = bns_pkg::sat32(h01_reg);
        hw11  = bns_pkg::sat32(h11_reg);
        nrows_clamp = (rows_reg > 4'(bns_pkg::MAX_ROWS)) ?
                      bns_pkg::ROW_CW'(bns_pkg::MAX_ROWS) : bns_pkg::ROW_CW'(rows_reg);
    end

    // next state, multiplier operands, divider launch
    always_comb
    begin
        state_next = state_reg;
        mul_a      = '0;
        mul_b      = '0;
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = s_reg;
        case (state_reg)
            bns_pkg::S_IDLE:
            begin
                if (accept && cmd.operation == bns_pkg::OP_STEP)
                    state_next = (nrows_clamp == '0) ? bns_pkg::S_DET0 : bns_pkg::S_RD;
            end
            bns_pkg::S_RD:  state_next = bns_pkg::S_M0;
            bns_pkg::S_M0:
            begin
                mul_a = rd_row.a0;
                mul_b = x0_reg;
                state_next = bns_pkg::S_M1;
            end
            bns_pkg::S_M1:
            begin
                mul_a = rd_row.a1;
                mul_b = x1_reg;
                state_next = bns_pkg::S_SLACK;
            end
            bns_pkg::S_SLACK:
                state_next = (slack == '0) ? bns_pkg::S_DONE : bns_pkg::S_U0;
            bns_pkg::S_U0:
            begin
                div_start  = 1'b1;
                div_num    = 64'(rd_row.a0);
                state_next = bns_pkg::S_U0W;
            end
            bns_pkg::S_U0W: if (div_done) state_next = bns_pkg::S_U1;
            bns_pkg::S_U1:
            begin
                div_start  = 1'b1;
                div_num    = 64'(rd_row.a1);
                state_next = bns_pkg::S_U1W;
            end
            bns_pkg::S_U1W: if (div_done) state_next = bns_pkg::S_Q0;
            bns_pkg::S_Q0:
            begin
                mul_a = u0_reg;
                mul_b = u0_reg;
                state_next = bns_pkg::S_Q1;
            end
            bns_pkg::S_Q1:
            begin
                mul_a = u0_reg;
                mul_b = u1_reg;
                state_next = bns_pkg::S_Q2;
            end
            bns_pkg::S_Q2:
            begin
                mul_a = u1_reg;
                mul_b = u1_reg;
                state_next = bns_pkg::S_Q3;
            end
            bns_pkg::S_Q3:
                state_next = (idx_reg + 1'b1 == nrows_reg) ? bns_pkg::S_DET0 : bns_pkg::S_RD;
            bns_pkg::S_DET0:
            begin
                mul_a = hw00;
                mul_b = hw11;
                state_next = bns_pkg::S_DET1;
            end
            bns_pkg::S_DET1:
            begin
                mul_a = hw01;
                mul_b = hw01;
                state_next = bns_pkg::S_N0A;
            end
            bns_pkg::S_N0A:
            begin
                mul_a = hw11;
                mul_b = c0_reg;
                state_next = (pa_reg == prod_reg) ? bns_pkg::S_DONE : bns_pkg::S_N0B;
            end
            bns_pkg::S_N0B:
            begin
                mul_a = hw01;
                mul_b = c1_reg;
                state_next = bns_pkg::S_N0C;
            end
            bns_pkg::S_N0C:
            begin
                mul_a = hw00;
                mul_b = c1_reg;
                state_next = bns_pkg::S_N1B;
            end
            bns_pkg::S_N1B:
            begin
                mul_a = hw01;
                mul_b = c0_reg;
                state_next = bns_pkg::S_N1C;
            end
            bns_pkg::S_N1C: state_next = bns_pkg::S_D0;
            bns_pkg::S_D0:
            begin
                div_start  = 1'b1;
                div_num    = n0_reg;
                div_den    = det_reg;
                state_next = bns_pkg::S_D0W;
            end
            bns_pkg::S_D0W: if (div_done) state_next = bns_pkg::S_D1;
            bns_pkg::S_D1:
            begin
                div_start  = 1'b1;
                div_num    = n1_reg;
                div_den    = det_reg;
                state_next = bns_pkg::S_D1W;
            end
            bns_pkg::S_D1W: if (div_done) state_next = bns_pkg::S_UPD;
            bns_pkg::S_UPD: state_next = bns_pkg::S_DONE;
            bns_pkg::S_DONE: state_next = bns_pkg::S_IDLE;
            default:        state_next = bns_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= bns_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // control state: configuration, point, counter, result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c0_reg    <= bns_pkg::DIR_RESET;
            c1_reg    <= bns_pkg::DIR_RESET;
            rows_reg  <= bns_pkg::ROWS_RESET;
            x0_reg    <= '0;
            x1_reg    <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            fault_reg <= bns_pkg::FAULT_OK;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    bns_pkg::CFG_DIR_C0: c0_reg   <= cfg_data;
                    bns_pkg::CFG_DIR_C1: c1_reg   <= cfg_data;
                    bns_pkg::CFG_ROWS:   rows_reg <= cfg_data[3:0];
                    default:             ;
                endcase
            end

            // strobe one beat after a start command or at the end of a step
            done_reg <= (accept && cmd.operation == bns_pkg::OP_START) ||
                        (state_reg == bns_pkg::S_DONE);
            if (accept && cmd.operation == bns_pkg::OP_START)
            begin
                // restart numbering and emit the new point as point 0
                x0_reg   <= cmd.start_x0;
                x1_reg   <= cmd.start_x1;
                cnt_reg  <= 16'd1;
            end
            if (accept && cmd.operation == bns_pkg::OP_STEP)
                fault_reg <= bns_pkg::FAULT_OK;
            if (state_reg == bns_pkg::S_SLACK && slack == '0)
                fault_reg <= bns_pkg::FAULT_SLACK;
            if (state_reg == bns_pkg::S_N0A && pa_reg == prod_reg)
                fault_reg <= bns_pkg::FAULT_SING;
            if (state_reg == bns_pkg::S_UPD)
            begin
                x0_reg <= bns_pkg::sat32(64'(x0_reg) - 64'(d0_reg));
                x1_reg <= bns_pkg::sat32(64'(x1_reg) - 64'(div_quo));
            end
            if (state_reg == bns_pkg::S_DONE)
            begin
                cnt_reg  <= cnt_reg + 16'd1;
            end
        end
    end

    // payload: products, accumulators, result beat
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;

        if (accept && cmd.operation == bns_pkg::OP_STEP)
        begin
            h00_reg   <= '0;
            h01_reg   <= '0;
            h11_reg   <= '0;
            idx_reg   <= '0;
            nrows_reg <= nrows_clamp;
        end
        if (accept && cmd.operation == bns_pkg::OP_START)
            res_reg <= {cmd.start_x0, cmd.start_x1, 16'd0, bns_pkg::FAULT_OK};

        case (state_reg)
            bns_pkg::S_SLACK: t0_reg <= '0;
            default:          ;
        endcase
        if (state_reg == bns_pkg::S_M1)
            t0_reg <= tprod;
        if (state_reg == bns_pkg::S_SLACK)
            s_reg <= 64'(slack);
        if (state_reg == bns_pkg::S_U0W && div_done)
            u0_reg <= div_quo;
        if (state_reg == bns_pkg::S_U1W && div_done)
            u1_reg <= div_quo;
        if (state_reg == bns_pkg::S_Q1)
            h00_reg <= h00_reg + 64'(tprod);
        if (state_reg == bns_pkg::S_Q2)
            h01_reg <= h01_reg + 64'(tprod);
        if (state_reg == bns_pkg::S_Q3)
        begin
            h11_reg <= h11_reg + 64'(tprod);
            idx_reg <= idx_reg + 1'b1;
        end
        if (state_reg == bns_pkg::S_DET1 || state_reg == bns_pkg::S_N0B ||
            state_reg == bns_pkg::S_N1B)
            pa_reg <= prod_reg;
        if (state_reg == bns_pkg::S_N0A)
            det_reg <= pa_reg - prod_reg;
        if (state_reg == bns_pkg::S_N0C)
            n0_reg <= bns_pkg::sat64(65'(pa_reg) - 65'(prod_reg));
        if (state_reg == bns_pkg::S_N1C)
            n1_reg <= bns_pkg::sat64(65'(pa_reg) - 65'(prod_reg));
        if (state_reg == bns_pkg::S_D0W && div_done)
            d0_reg <= div_quo;
        if (state_reg == bns_pkg::S_DONE)
            res_reg <= {x0_reg, x1_reg, cnt_reg, fault_reg};
    end

    assign done   = done_reg;
    assign result = res_reg;

`ifndef ASSERT_OFF
    // a step always ends with exactly one result beat
    a_step_emits: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("step finished without a result beat");

    // loads produce no result
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.operation == bns_pkg::OP_LOAD) |=> !done)
        else $error("load produced a result beat");

    // a faulted step leaves the point untouched
    a_fault_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.fault != bns_pkg::FAULT_OK) |->
        (result.point_x0 == x0_reg && result.point_x1 == x1_reg))
        else $error("faulted step moved the point");
`endif

endmodule
